[rtl/core/ipmac_pkg.sv]
package ipmac_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W = 32;
    localparam int MAC_W = 48;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;

    typedef logic [IDX_W-1:0] t_slot;
    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic              rd_en;
        t_slot             rd_slot;
        logic              wr_en;
        t_slot             wr_slot;
        logic [KEY_W-1:0]  wr_key;
        logic [MAC_W-1:0]  wr_mac;
    } t_mem_req;

endpackage

[rtl/core/ipv4_to_mac_mapping_table.sv]
// Maps nonzero IPv4 keys to 48-bit hardware addresses in a 16-entry table kept
// in synchronous memory, oldest entry evicted first when a new key arrives on a
// full table. One item is handled at a time: accept, a check step, then a
// search that reads one entry per cycle from the oldest onward (bounded by the
// number of live entries, skipped when the check fails or the table is empty)
// and a last step that hands the result to the output register once it is
// free. The result waits in that register while the next item is accepted. Any
// write to the link enable register clears the table at once; operations fail
// while the link is off or when the key is zero.
module ipv4_to_mac_mapping_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_link_enabled,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [ipmac_pkg::KEY_W-1:0] i_ipv4_address,
    input  logic [ipmac_pkg::MAC_W-1:0] i_mac_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_success,
    output logic [ipmac_pkg::KEY_W-1:0] o_ipv4_result,
    output logic [ipmac_pkg::MAC_W-1:0] o_mac_result
);
    import ipmac_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_FIN
    } t_state;

    localparam t_slot        LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
    localparam t_count       FULL_CNT  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W:0] WRAP    = (CNT_W + 1)'(TABLE_ENTRIES);

    function automatic t_slot next_slot(input t_slot s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic t_slot slot_add(input t_slot s, input t_count c);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(s) + (CNT_W + 1)'(c);
        if (sum >= WRAP) begin
            sum = sum - WRAP;
        end
        slot_add = sum[IDX_W-1:0];
    endfunction

    t_state           r_state, n_state;
    logic             r_link, n_link;
    t_slot            r_head, n_head;
    t_count           r_count, n_count;
    t_slot            r_slot, n_slot;
    t_count           r_pos, n_pos;
    logic             r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [MAC_W-1:0] r_mac, n_mac;
    logic             r_res_ok, n_res_ok;
    logic [KEY_W-1:0] r_res_key, n_res_key;
    logic [MAC_W-1:0] r_res_mac, n_res_mac;
    logic             r_out_valid, n_out_valid;
    logic             r_out_ok, n_out_ok;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [MAC_W-1:0] r_out_mac, n_out_mac;

    t_mem_req         mem_req;
    logic [KEY_W-1:0] rd_key;
    logic [MAC_W-1:0] rd_mac;
    logic             do_hit;
    logic             do_miss;

    ipmac_store u_store (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_key (rd_key),
        .o_rd_mac (rd_mac)
    );

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;

    always_comb begin
        n_state     = r_state;
        n_link      = r_link;
        n_head      = r_head;
        n_count     = r_count;
        n_slot      = r_slot;
        n_pos       = r_pos;
        n_op        = r_op;
        n_key       = r_key;
        n_mac       = r_mac;
        n_res_ok    = r_res_ok;
        n_res_key   = r_res_key;
        n_res_mac   = r_res_mac;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_key   = r_out_key;
        n_out_mac   = r_out_mac;
        mem_req     = '0;
        do_hit      = 1'b0;
        do_miss     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_link  = i_cfg_link_enabled;
                    n_head  = '0;
                    n_count = '0;
                end else if (i_in_valid) begin
                    n_op    = i_operation;
                    n_key   = i_ipv4_address;
                    n_mac   = i_mac_address;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (!r_link || r_key == '0) begin
                    n_res_ok  = 1'b0;
                    n_res_key = '0;
                    n_res_mac = '0;
                    n_state   = ST_FIN;
                end else if (r_count == '0) begin
                    do_miss = 1'b1;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_slot = r_head;
                    n_slot          = r_head;
                    n_pos           = '0;
                    n_state         = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (rd_key == r_key) begin
                    do_hit = 1'b1;
                end else if (CNT_W'(r_pos + 1'b1) == r_count) begin
                    do_miss = 1'b1;
                end else begin
                    n_pos           = CNT_W'(r_pos + 1'b1);
                    n_slot          = next_slot(r_slot);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_slot = next_slot(r_slot);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_key   = r_res_key;
                    n_out_mac   = r_res_mac;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_hit) begin
            n_res_ok  = 1'b1;
            n_res_key = r_key;
            n_state   = ST_FIN;
            if (r_op == OP_REGISTER) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_slot = r_slot;
                mem_req.wr_key  = r_key;
                mem_req.wr_mac  = r_mac;
                n_res_mac       = '0;
            end else begin
                n_res_mac = rd_mac;
            end
        end

        if (do_miss) begin
            n_res_mac = '0;
            n_state   = ST_FIN;
            if (r_op == OP_REGISTER) begin
                n_res_ok       = 1'b1;
                n_res_key      = r_key;
                mem_req.wr_en  = 1'b1;
                mem_req.wr_key = r_key;
                mem_req.wr_mac = r_mac;
                if (r_count == FULL_CNT) begin
                    // full table, new entry replaces the oldest
                    mem_req.wr_slot = r_head;
                    n_head          = next_slot(r_head);
                end else begin
                    mem_req.wr_slot = slot_add(r_head, r_count);
                    n_count         = CNT_W'(r_count + 1'b1);
                end
            end else begin
                n_res_ok  = 1'b0;
                n_res_key = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_pos       <= n_pos;
        r_op        <= n_op;
        r_key       <= n_key;
        r_mac       <= n_mac;
        r_res_ok    <= n_res_ok;
        r_res_key   <= n_res_key;
        r_res_mac   <= n_res_mac;
        r_out_ok    <= n_out_ok;
        r_out_key   <= n_out_key;
        r_out_mac   <= n_out_mac;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_link      <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_link      <= n_link;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_out_ok;
    assign o_ipv4_result = r_out_key;
    assign o_mac_result  = r_out_mac;

endmodule

[rtl/core/ipmac_store.sv]
module ipmac_store (
    input  logic                       i_clk,
    input  ipmac_pkg::t_mem_req        i_req,
    output logic [ipmac_pkg::KEY_W-1:0] o_rd_key,
    output logic [ipmac_pkg::MAC_W-1:0] o_rd_mac
);
    import ipmac_pkg::*;

    logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
    logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
    logic [KEY_W-1:0] r_rd_key;
    logic [MAC_W-1:0] r_rd_mac;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            key_mem[i_req.wr_slot] <= i_req.wr_key;
            mac_mem[i_req.wr_slot] <= i_req.wr_mac;
        end
        if (i_req.rd_en) begin
            r_rd_key <= key_mem[i_req.rd_slot];
            r_rd_mac <= mac_mem[i_req.rd_slot];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_mac = r_rd_mac;

endmodule

[tb/sv/ipv4_to_mac_mapping_table_tb.sv]
module ipv4_to_mac_mapping_table_tb;
    import ipmac_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_AT     = 500;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [MAC_W-1:0] mac;
        bit               drain_first;
    } t_map_req;

    typedef struct {
        logic             ok;
        logic [KEY_W-1:0] key;
        logic [MAC_W-1:0] mac;
    } t_map_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_link_enabled = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_operation = OP_REGISTER;
    logic [KEY_W-1:0] i_ipv4_address = '0;
    logic [MAC_W-1:0] i_mac_address = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_success;
    logic [KEY_W-1:0] o_ipv4_result;
    logic [MAC_W-1:0] o_mac_result;

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key [TABLE_ENTRIES];
    logic [MAC_W-1:0] shadow_mac [TABLE_ENTRIES];
    t_slot            shadow_head = '0;
    int               shadow_count = 0;
    logic             shadow_link = 1'b0;

    t_map_req         pending_reqs [$];
    t_map_reply       expected_replies [$];
    logic [KEY_W-1:0] key_pool [$];
    t_map_req         cur_req;
    t_map_reply       want;

    int  in_gap = 0;
    int  out_gap = 0;
    bit  no_idle = 1'b0;
    int  quiet_cycles = 0;
    int  sent_items = 0;
    int  replies_seen = 0;
    int  mismatch_count = 0;
    int  hit_count = 0;
    int  miss_count = 0;
    int  reject_count = 0;
    int  evict_count = 0;
    int  link_writes = 0;

    ipv4_to_mac_mapping_table uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_link_enabled (i_cfg_link_enabled),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_ipv4_address     (i_ipv4_address),
        .i_mac_address      (i_mac_address),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_success          (o_success),
        .o_ipv4_result      (o_ipv4_result),
        .o_mac_result       (o_mac_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_map_reply resolve_mapping(input t_map_req req);
        t_map_reply rep;
        bit         found;
        t_slot      hit_slot;
        t_slot      s;
        rep = '{1'b0, '0, '0};
        found = 1'b0;
        hit_slot = '0;
        if (!shadow_link || req.key == '0) begin
            reject_count++;
            return rep;
        end
        for (int i = 0; i < shadow_count; i++) begin
            s = shadow_head + t_slot'(i);
            if (!found && shadow_key[s] == req.key) begin
                found = 1'b1;
                hit_slot = s;
            end
        end
        if (req.op == OP_REGISTER) begin
            if (found) begin
                shadow_mac[hit_slot] = req.mac;
            end else if (shadow_count == TABLE_ENTRIES) begin
                shadow_key[shadow_head] = req.key;
                shadow_mac[shadow_head] = req.mac;
                shadow_head = shadow_head + 1'b1;
                evict_count++;
            end else begin
                s = shadow_head + t_slot'(shadow_count);
                shadow_key[s] = req.key;
                shadow_mac[s] = req.mac;
                shadow_count++;
            end
            rep.ok = 1'b1;
            rep.key = req.key;
        end else if (found) begin
            rep.ok = 1'b1;
            rep.key = req.key;
            rep.mac = shadow_mac[hit_slot];
            hit_count++;
        end else begin
            miss_count++;
        end
        return rep;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    function automatic void enqueue_req(input logic op, input logic [KEY_W-1:0] key,
                                        input logic [MAC_W-1:0] mac, input bit drain_first);
        t_map_req req;
        req = '{op, key, mac, drain_first};
        pending_reqs.push_back(req);
    endfunction

    function automatic void refill_pool(input int n);
        logic [KEY_W-1:0] k;
        key_pool.delete();
        repeat (n) begin
            k = $urandom;
            if (k == '0) k = 1;
            key_pool.push_back(k);
        end
    endfunction

    function automatic void enqueue_random(input bit drain_first);
        int               r;
        logic [KEY_W-1:0] key;
        logic             op;
        r = $urandom_range(0, 99);
        if (r < 3) key = '0;
        else if (r < 8) key = $urandom;
        else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        op = ($urandom_range(0, 99) < 45) ? OP_LOOKUP : OP_REGISTER;
        enqueue_req(op, key, rand_mac(), drain_first);
    endfunction

    // checked between edges so the driver has settled
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_link(input logic en);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_link_enabled <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_link = en;
        shadow_head = '0;
        shadow_count = 0;
        link_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_replies.push_back(resolve_mapping(cur_req));
                sent_items++;
                in_gap = pick_gap();
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain_first && expected_replies.size() > 0)) begin
                    cur_req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= cur_req.op;
                    i_ipv4_address <= cur_req.key;
                    i_mac_address <= cur_req.mac;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result success=%b ipv4=%h mac=%h",
                             $time, o_success, o_ipv4_result, o_mac_result);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_success !== want.ok) begin
                        $display("%0t: success expected %b actual %b", $time, want.ok, o_success);
                        mismatch_count++;
                    end
                    if (o_ipv4_result !== want.key) begin
                        $display("%0t: ipv4_result expected %h actual %h",
                                 $time, want.key, o_ipv4_result);
                        mismatch_count++;
                    end
                    if (o_mac_result !== want.mac) begin
                        $display("%0t: mac_result expected %h actual %h",
                                 $time, want.mac, o_mac_result);
                        mismatch_count++;
                    end
                end
                if (replies_seen == HOLD_AT) out_gap = LONG_HOLD;
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // link still down after reset
        enqueue_req(OP_REGISTER, 32'h0000_0001, 48'h0000_0000_0001, 1'b0);
        wait_idle();
        write_link(1'b1);

        enqueue_req(OP_REGISTER, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        enqueue_req(OP_REGISTER, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        enqueue_req(OP_LOOKUP,   32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
        enqueue_req(OP_REGISTER, 32'h0000_0001, 48'h0000_0000_0000, 1'b0);
        enqueue_req(OP_LOOKUP,   32'h0000_0001, 48'hFFFF_FFFF_FFFF, 1'b0);
        // in-place update keeps insertion order
        enqueue_req(OP_REGISTER, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 1'b0);
        enqueue_req(OP_LOOKUP,   32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
        for (int i = 0; i < 15; i++)
            enqueue_req(OP_REGISTER, 32'h0A00_0000 + i, 48'hA5A5_0000_0000 + i, 1'b0);
        enqueue_req(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
        enqueue_req(OP_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000, 1'b0);
        wait_idle();
        // rewrite while enabled clears the table
        write_link(1'b1);
        enqueue_req(OP_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            write_link((ph == 2 || ph == 5) ? 1'b0 : 1'b1);
            refill_pool($urandom_range(6, 40));
            no_idle = (ph == 3);
            for (int n = 0; n < ((ph == 2 || ph == 5) ? 60 : 240); n++)
                enqueue_random(ph == 1 && n == 120);
            wait_idle();
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("%0d items, %0d results: %0d lookup hits, %0d misses, %0d rejected",
                 sent_items, replies_seen, hit_count, miss_count, reject_count);
        $display("%0d evictions, %0d link writes, %0d mismatches",
                 evict_count, link_writes, mismatch_count);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
